FILE: rtl/core/fwrpos_pkg.sv
// ----------------------------------------------------------------------------
// fwrpos_pkg
// Shared constants, types and pointer helpers for the FIFO with removal at
// any position.
// ----------------------------------------------------------------------------
package fwrpos_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 16;

    // fixed port widths
    localparam int KIND_W = 1;
    localparam int IVAL_W = 16;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int RVAL_W = 16;
    localparam int OCC_W  = 5;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CAPTURE,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t                status;
        logic [VALUE_WIDTH-1:0] removed_value;
        logic [CNT_W-1:0]       occupancy;
    } res_t;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic                   re;
        logic [ADDR_W-1:0]      raddr;
    } ram_req_t;

    // circular increment
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == ADDR_W'(DEPTH - 1))
            r = '0;
        else
            r = a + 1'b1;
        return r;
    endfunction

    // circular add, offset below DEPTH
    function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, off};
        if (s >= (ADDR_W+1)'(DEPTH))
            s = s - (ADDR_W+1)'(DEPTH);
        return s[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/core/fifo_with_remove_at_position_top.sv
// Insert, refused insert, empty or out-of-range remove: IDLE, then RESP, then the output register.
// Remove at position p of n entries: IDLE, CAPTURE, a SHIFT step for each of the n - p later entries,
// then RESP; a dequeue (p = 1) only moves the head and skips SHIFT. The sweep moves one slot per cycle.
// One word in flight: no new word is taken until the last result has left RESP;
// a new word is taken while the last result waits in the output register.
// Reset (rst_n, async, active low) empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// fifo_with_remove_at_position_top
// Bounded FIFO whose entries sit in a circular RAM; any entry may be pulled
// out by position and the later entries close up behind it.
// ----------------------------------------------------------------------------
module fifo_with_remove_at_position_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fwrpos_pkg::KIND_W-1:0]      kind,
    input  logic [fwrpos_pkg::IVAL_W-1:0]      item_value,
    input  logic [fwrpos_pkg::POS_W-1:0]       position,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fwrpos_pkg::STAT_W-1:0]      status,
    output logic [fwrpos_pkg::RVAL_W-1:0]      removed_value,
    output logic [fwrpos_pkg::OCC_W-1:0]       occupancy
);

    fwrpos_pkg::ram_req_t                  ram_req;
    logic [fwrpos_pkg::VALUE_WIDTH-1:0]    ram_rdata;

    logic                                  res_valid;
    logic                                  res_take;
    fwrpos_pkg::res_t                      res;

    // output word register
    logic                                  out_valid_reg, out_valid_next;
    fwrpos_pkg::res_t                      out_res_reg, out_res_next;
    logic                                  slot_free;

    fwrpos_ram #(
        .DEPTH_P (fwrpos_pkg::DEPTH),
        .WIDTH_P (fwrpos_pkg::VALUE_WIDTH),
        .ADDR_P  (fwrpos_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    fwrpos_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .item_value (item_value),
        .position   (position),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // the result register frees up on the same cycle it is drained
    assign slot_free = !out_valid_reg || out_ready;
    assign res_take  = res_valid && slot_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign removed_value = fwrpos_pkg::RVAL_W'(out_res_reg.removed_value);
    assign occupancy     = fwrpos_pkg::OCC_W'(out_res_reg.occupancy);

endmodule

FILE: rtl/core/fwrpos_ram.sv
// ----------------------------------------------------------------------------
// fwrpos_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fwrpos_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 16,
    parameter int ADDR_P  = 4
) (
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_P-1:0]  waddr,
    input  logic [WIDTH_P-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_P-1:0]  raddr,
    output logic [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fwrpos_ctrl.sv
// ----------------------------------------------------------------------------
// fwrpos_ctrl
// Sequencer: head/count bookkeeping, range checks, and the read-then-write
// sweep that closes the gap after a removal.
// ----------------------------------------------------------------------------
module fwrpos_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fwrpos_pkg::KIND_W-1:0]        kind,
    input  logic [fwrpos_pkg::IVAL_W-1:0]        item_value,
    input  logic [fwrpos_pkg::POS_W-1:0]         position,
    output fwrpos_pkg::ram_req_t                 ram_req,
    input  logic [fwrpos_pkg::VALUE_WIDTH-1:0]   ram_rdata,
    output logic                                 res_valid,
    input  logic                                 res_take,
    output fwrpos_pkg::res_t                     res
);

    fwrpos_pkg::state_t                    state_reg, state_next;
    logic [fwrpos_pkg::ADDR_W-1:0]         head_reg, head_next;
    logic [fwrpos_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [fwrpos_pkg::ADDR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [fwrpos_pkg::ADDR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [fwrpos_pkg::CNT_W-1:0]          left_reg, left_next;
    logic                                  adv_reg, adv_next;
    fwrpos_pkg::res_t                      res_reg, res_next;

    logic                                  accept;
    logic                                  is_full;
    logic                                  is_empty;
    logic                                  pos_bad;
    logic [fwrpos_pkg::ADDR_W-1:0]         tail_addr;
    logic [fwrpos_pkg::ADDR_W-1:0]         pos_addr;
    logic [fwrpos_pkg::CNT_W-1:0]          pos_c;

    assign in_ready  = (state_reg == fwrpos_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == fwrpos_pkg::S_RESP);
    assign res       = res_reg;

    assign is_full  = (count_reg == fwrpos_pkg::CNT_W'(fwrpos_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (position == '0)
                   || (fwrpos_pkg::CMP_W'(position) > fwrpos_pkg::CMP_W'(count_reg));
    // only used once the position is known to lie in 1..count
    assign pos_c     = fwrpos_pkg::CNT_W'(position);
    assign tail_addr = fwrpos_pkg::ptr_add(head_reg, fwrpos_pkg::ADDR_W'(count_reg));
    assign pos_addr  = fwrpos_pkg::ptr_add(head_reg,
                                           fwrpos_pkg::ADDR_W'(pos_c - 1'b1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fwrpos_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == fwrpos_pkg::KIND_REMOVE && !is_empty && !pos_bad)
                        state_next = fwrpos_pkg::S_CAPTURE;
                    else
                        state_next = fwrpos_pkg::S_RESP;
                end
            end
            fwrpos_pkg::S_CAPTURE:
            begin
                if (left_reg != '0)
                    state_next = fwrpos_pkg::S_SHIFT;
                else
                    state_next = fwrpos_pkg::S_RESP;
            end
            fwrpos_pkg::S_SHIFT:
            begin
                if (left_reg == fwrpos_pkg::CNT_W'(1))
                    state_next = fwrpos_pkg::S_RESP;
            end
            fwrpos_pkg::S_RESP:
            begin
                if (res_take)
                    state_next = fwrpos_pkg::S_IDLE;
            end
            default:
                state_next = fwrpos_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        left_next   = left_reg;
        adv_next    = adv_reg;
        res_next    = res_reg;
        ram_req     = '0;
        case (state_reg)
            fwrpos_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_next.removed_value = '0;
                    res_next.occupancy     = count_reg;
                    res_next.status        = fwrpos_pkg::ST_OK;
                    if (kind == fwrpos_pkg::KIND_INSERT)
                    begin
                        if (is_full)
                            res_next.status = fwrpos_pkg::ST_FULL;
                        else
                        begin
                            ram_req.we         = 1'b1;
                            ram_req.waddr      = tail_addr;
                            ram_req.wdata      = fwrpos_pkg::VALUE_WIDTH'(item_value);
                            count_next         = count_reg + 1'b1;
                            res_next.occupancy = count_reg + 1'b1;
                        end
                    end
                    else if (is_empty)
                        res_next.status = fwrpos_pkg::ST_EMPTY;
                    else if (pos_bad)
                        res_next.status = fwrpos_pkg::ST_RANGE;
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = pos_addr;
                        rd_ptr_next   = fwrpos_pkg::ptr_inc(pos_addr);
                        wr_ptr_next   = pos_addr;
                        // a plain dequeue just moves the head
                        adv_next      = (pos_c == fwrpos_pkg::CNT_W'(1));
                        left_next     = (pos_c == fwrpos_pkg::CNT_W'(1)) ? '0
                                                                         : count_reg - pos_c;
                    end
                end
            end
            fwrpos_pkg::S_CAPTURE:
            begin
                res_next.removed_value = ram_rdata;
                if (left_reg != '0)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rd_ptr_reg;
                    rd_ptr_next   = fwrpos_pkg::ptr_inc(rd_ptr_reg);
                end
                else
                begin
                    count_next         = count_reg - 1'b1;
                    res_next.occupancy = count_reg - 1'b1;
                    if (adv_reg)
                        head_next = fwrpos_pkg::ptr_inc(head_reg);
                end
            end
            fwrpos_pkg::S_SHIFT:
            begin
                // word read last cycle drops one slot toward the head
                ram_req.we    = 1'b1;
                ram_req.waddr = wr_ptr_reg;
                ram_req.wdata = ram_rdata;
                wr_ptr_next   = fwrpos_pkg::ptr_inc(wr_ptr_reg);
                left_next     = left_reg - 1'b1;
                if (left_reg > fwrpos_pkg::CNT_W'(1))
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rd_ptr_reg;
                    rd_ptr_next   = fwrpos_pkg::ptr_inc(rd_ptr_reg);
                end
                else
                begin
                    count_next         = count_reg - 1'b1;
                    res_next.occupancy = count_reg - 1'b1;
                end
            end
            fwrpos_pkg::S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwrpos_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        left_reg   <= left_next;
        adv_reg    <= adv_next;
        res_reg    <= res_next;
    end

    // occupancy bounded by the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fwrpos_pkg::CNT_W'(fwrpos_pkg::DEPTH))
        else $error("occupancy above depth");

    // occupancy moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg + 1'b1 == $past(count_reg)))
        else $error("occupancy jumped");

    // during the sweep, read and write never hit the same slot
    a_sweep_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fwrpos_pkg::S_SHIFT && ram_req.re) |-> (ram_req.raddr != ram_req.waddr))
        else $error("sweep read/write collision");

    // an accepted word always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != fwrpos_pkg::S_IDLE))
        else $error("accepted word not taken up");

endmodule

FILE: bench/fifo_with_remove_at_position_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_with_remove_at_position_top_test
// Self-checking bench for the FIFO with removal at any position. A short
// directed sequence (empty, full, range edges) is followed by random traffic
// in fill and drain phases. A queue model predicts every result, and random
// gaps on both handshakes exercise stalls on the input and result channels.
// ----------------------------------------------------------------------------
module fifo_with_remove_at_position_top_test;

    // one input word as queued for the driver
    typedef struct packed {
        logic [fwrpos_pkg::KIND_W-1:0] kind;
        logic [fwrpos_pkg::IVAL_W-1:0] value;
        logic [fwrpos_pkg::POS_W-1:0]  pos;
    } stim_word_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [fwrpos_pkg::KIND_W-1:0]     kind = fwrpos_pkg::KIND_INSERT;
    logic [fwrpos_pkg::IVAL_W-1:0]     item_value = '0;
    logic [fwrpos_pkg::POS_W-1:0]      position = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [fwrpos_pkg::STAT_W-1:0]     status;
    logic [fwrpos_pkg::RVAL_W-1:0]     removed_value;
    logic [fwrpos_pkg::OCC_W-1:0]      occupancy;

    // stimulus waiting for the driver, and its running occupancy estimate
    stim_word_t          pending_words[$];
    int unsigned         words_planned = 0;
    int unsigned         planned_count = 0;

    // queue model: oldest entry at index 0
    logic [fwrpos_pkg::VALUE_WIDTH-1:0] held_values[$];
    fwrpos_pkg::res_t                   awaited_results[$];

    int unsigned         words_accepted = 0;
    int unsigned         error_count = 0;
    int unsigned         inserts_ok = 0;
    int unsigned         removes_ok = 0;
    int unsigned         full_hits = 0;
    int unsigned         empty_hits = 0;
    int unsigned         range_hits = 0;

    // handshake pacing state
    logic                in_accepted = 1'b0;
    int                  send_pause = 0;
    int                  send_steady = 0;
    int                  take_pause = 0;
    int                  take_steady = 0;

    fifo_with_remove_at_position_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .item_value    (item_value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .removed_value (removed_value),
        .occupancy     (occupancy)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no pause or a short one; now and then a long one.
    function automatic int draw_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(8, 40));
    endfunction

    // Queue a word for the driver and track the occupancy it will leave,
    // so that the random part can aim positions at live entries.
    task automatic queue_word(input logic [fwrpos_pkg::KIND_W-1:0] k,
                              input logic [fwrpos_pkg::IVAL_W-1:0] v,
                              input logic [fwrpos_pkg::POS_W-1:0] p);
        stim_word_t w;
        w.kind  = k;
        w.value = v;
        w.pos   = p;
        pending_words.push_back(w);
        words_planned++;
        if (k == fwrpos_pkg::KIND_INSERT)
        begin
            if (planned_count < fwrpos_pkg::DEPTH)
                planned_count++;
        end
        else if (planned_count != 0 && p != 0 && p <= planned_count)
            planned_count--;
    endtask

    // Queue behaviour for one accepted word; pushes the result it must yield.
    function automatic void apply_word(input logic [fwrpos_pkg::KIND_W-1:0] k,
                                       input logic [fwrpos_pkg::IVAL_W-1:0] v,
                                       input logic [fwrpos_pkg::POS_W-1:0] p);
        fwrpos_pkg::res_t r;
        r.status        = fwrpos_pkg::ST_OK;
        r.removed_value = '0;
        if (k == fwrpos_pkg::KIND_INSERT)
        begin
            if (held_values.size() >= fwrpos_pkg::DEPTH)
                r.status = fwrpos_pkg::ST_FULL;
            else
            begin
                held_values.push_back(v[fwrpos_pkg::VALUE_WIDTH-1:0]);
                inserts_ok++;
            end
        end
        else if (held_values.size() == 0)
            r.status = fwrpos_pkg::ST_EMPTY;    // empty wins over a bad position
        else if (p == 0 || p > held_values.size())
            r.status = fwrpos_pkg::ST_RANGE;
        else
        begin
            r.removed_value = held_values[p - 1];
            held_values.delete(p - 1);  // later entries close up in order
            removes_ok++;
        end
        r.occupancy = fwrpos_pkg::CNT_W'(held_values.size());
        awaited_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued words at the falling edge. A word stays put until
    // the monitor saw it taken; between words it may idle for a while, or run
    // a stretch of back-to-back words.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_accepted)
        begin
            if (send_pause > 0)
            begin
                in_valid   <= 1'b0;
                send_pause <= send_pause - 1;
            end
            else if (pending_words.size() > 0)
            begin
                in_valid   <= 1'b1;
                kind       <= pending_words[0].kind;
                item_value <= pending_words[0].value;
                position   <= pending_words[0].pos;
                pending_words.delete(0);
                if (send_steady > 0)
                    send_steady <= send_steady - 1;
                else if ($urandom_range(0, 29) == 0)
                    send_steady <= $urandom_range(20, 60);
                else
                    send_pause <= draw_pause();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side back-pressure, also changed at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (take_pause > 0)
        begin
            out_ready  <= 1'b0;
            take_pause <= take_pause - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (take_steady > 0)
                take_steady <= take_steady - 1;
            else if ($urandom_range(0, 99) == 0)
                take_steady <= $urandom_range(30, 80);
            else if ($urandom_range(0, 3) == 0)
                take_pause <= draw_pause();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, predict for every word taken on the input
    // and check every word delivered on the output against the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        fwrpos_pkg::res_t want;
        in_accepted <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_word(kind, item_value, position);
                words_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with nothing outstanding: status %0d value %0h occ %0d",
                           status, removed_value, occupancy);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (removed_value !== want.removed_value)
                    begin
                        $error("removed_value: expected %0h, got %0h",
                               want.removed_value, removed_value);
                        error_count++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                        error_count++;
                    end
                    case (want.status)
                        fwrpos_pkg::ST_FULL:  full_hits++;
                        fwrpos_pkg::ST_EMPTY: empty_hits++;
                        fwrpos_pkg::ST_RANGE: range_hits++;
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          phase_left;
        int unsigned insert_share;
        int unsigned r;
        logic [fwrpos_pkg::IVAL_W-1:0] v;
        logic [fwrpos_pkg::POS_W-1:0]  p;

        // directed: empty queue, fill to the brim, then the range edges
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'h1234, 5'd1);   // dequeue from empty
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'hFFFF, 5'd0);   // empty beats position zero
        queue_word(fwrpos_pkg::KIND_INSERT, 16'hFFFF, 5'd31);
        queue_word(fwrpos_pkg::KIND_INSERT, 16'h0000, 5'd0);
        queue_word(fwrpos_pkg::KIND_INSERT, 16'hAAAA, 5'd0);
        queue_word(fwrpos_pkg::KIND_INSERT, 16'h5555, 5'd0);
        for (int i = 4; i < fwrpos_pkg::DEPTH; i++)
            queue_word(fwrpos_pkg::KIND_INSERT,
                       fwrpos_pkg::IVAL_W'(16'h1000 + i * 16'h0111),
                       fwrpos_pkg::POS_W'(i));
        queue_word(fwrpos_pkg::KIND_INSERT, 16'hDEAD, 5'd0);   // refused, queue full
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'h0000, 5'd17);  // just past the tail
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'h0000, 5'd16);  // the newest entry
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'h0000, 5'd0);   // position zero
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'h0000, 5'd31);  // largest position code
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'h0000, 5'd1);   // plain dequeue
        queue_word(fwrpos_pkg::KIND_REMOVE, 16'h0000, 5'd8);   // from the middle

        // random: phases that lean towards filling, draining or neither
        phase_left = 0;
        insert_share = 50;
        for (int n = 0; n < 400; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0:       insert_share = 85;
                    1:       insert_share = 15;
                    default: insert_share = 50;
                endcase
            end
            phase_left--;

            r = $urandom_range(0, 9);
            v = (r == 0) ? '0 : (r == 1) ? '1 : fwrpos_pkg::IVAL_W'($urandom);

            r = $urandom_range(0, 9);
            if (r == 0)
                p = 5'd1;
            else if (r == 1 && planned_count != 0)
                p = fwrpos_pkg::POS_W'(planned_count);
            else if (r <= 2 || planned_count == 0)
                p = fwrpos_pkg::POS_W'($urandom_range(0, 31));
            else
                p = fwrpos_pkg::POS_W'($urandom_range(1, planned_count));

            if ($urandom_range(0, 99) < insert_share)
                queue_word(fwrpos_pkg::KIND_INSERT, v, p);
            else
                queue_word(fwrpos_pkg::KIND_REMOVE, v, p);
        end

        // reset held first, then released away from the active edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_accepted < words_planned || awaited_results.size() != 0)
            @(negedge clk);
        // catch stray results after the last expected one
        repeat (30) @(negedge clk);

        $display("Ran %0d words: %0d inserts and %0d removals done,", words_accepted,
                 inserts_ok, removes_ok);
        $display("%0d refused when full, %0d on empty, %0d out of range.", full_hits,
                 empty_hits, range_hits);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
